### sv/line_lexer_tokenizer_core_macros.svh
// ----------------------------------------------------------------------------
// line lexer tokenizer assertion macros
// clocked concurrent property wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef LINE_LEXER_TOKENIZER_CORE_MACROS_SVH
`define LINE_LEXER_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LLT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LLT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LLT_ASSERT(label, cond, msg)
`define LLT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### sv/llt_pkg.sv
// ----------------------------------------------------------------------------
// llt_pkg
// types, character codes and helpers shared by the line lexer
// ----------------------------------------------------------------------------
`default_nettype none

package llt_pkg;

    localparam int unsigned LINE_LENGTH = 1024;
    localparam int unsigned COL_W       = 10;
    localparam int unsigned LEN_W       = 10;
    localparam logic [COL_W-1:0] COL_MAX =
        (LINE_LENGTH - 1 < 1023) ? COL_W'(LINE_LENGTH - 1) : COL_W'(1023);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam int unsigned LIMIT_W     = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd12;

    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] KW_PRINT    = 64'h0000_0074_6E69_7270;
    localparam logic [63:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;
    localparam logic [63:0] KW_RETURN   = 64'h0000_6E72_7574_6572;
    localparam logic [LEN_W-1:0] KW_PRINT_LEN    = 10'd5;
    localparam logic [LEN_W-1:0] KW_FUNCTION_LEN = 10'd8;
    localparam logic [LEN_W-1:0] KW_RETURN_LEN   = 10'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;

    localparam logic [ADDR_W-1:0] REG_IDENT_LIMIT = 3'd0;

    typedef enum logic [3:0] {
        TK_IDENT    = 4'd0,
        TK_NUMBER   = 4'd1,
        TK_ASSIGN   = 4'd2,
        TK_OPER     = 4'd3,
        TK_PRINT    = 4'd4,
        TK_FUNCTION = 4'd5,
        TK_RETURN   = 4'd6,
        TK_LPAREN   = 4'd7,
        TK_RPAREN   = 4'd8,
        TK_COMMA    = 4'd9,
        TK_END      = 4'd10,
        TK_INDENT   = 4'd11,
        TK_ERROR    = 4'd12
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_LINE_START,
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_LT,
        MODE_INDENT,
        MODE_COMMENT,
        MODE_ERROR
    } scan_mode_t;

    typedef struct packed {
        tok_kind_t         kind;
        logic [7:0]        symbol;
        logic [COL_W-1:0]  start_column;
        logic [LEN_W-1:0]  token_length;
        logic              too_long;
        logic              last;
    } token_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_end(input logic [7:0] c);
        return c == CH_LF || c == CH_NUL;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic token_t make_tok(input tok_kind_t k, input logic [7:0] sym,
                                        input logic [COL_W-1:0] col,
                                        input logic [LEN_W-1:0] len,
                                        input logic flag);
        token_t t;
        t.kind         = k;
        t.symbol       = sym;
        t.start_column = col;
        t.token_length = len;
        t.too_long     = flag;
        t.last         = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

### sv/llt_ifs.sv
// ----------------------------------------------------------------------------
// llt channel interfaces
// character input channel and token output channel
// ----------------------------------------------------------------------------
`default_nettype none

interface llt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface llt_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] symbol;
    logic [9:0] start_column;
    logic [9:0] token_length;
    logic       too_long;
    logic       last;

    modport source (output valid, output token_kind, output symbol, output start_column,
                    output token_length, output too_long, output last, input ready);
    modport sink   (input valid, input token_kind, input symbol, input start_column,
                    input token_length, input too_long, input last, output ready);
endinterface

`default_nettype wire

### sv/llt_scan.sv
// ----------------------------------------------------------------------------
// llt_scan
// scanner state and per-character token logic, up to two tokens per character
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_lexer_tokenizer_core_macros.svh"

module llt_scan
    import llt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [7:0]         ch,
    input  wire logic [LIMIT_W-1:0] limit,
    output push_t                   push
);

    scan_mode_t        mode_reg, mode_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [COL_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [63:0]       prefix_reg, prefix_next;

    scan_mode_t        d_mode;
    logic              d_emit;
    token_t            d_tok;
    logic              d_word;
    logic              d_load_len;

    logic              pend_v;
    token_t            pend_tok;
    logic              do_disp;
    tok_kind_t         word_kind;
    logic              word_flag;
    logic [LEN_W-1:0]  length_grown;

    assign length_grown = (length_reg < LEN_MAX) ? length_reg + 1'b1 : length_reg;

    always_comb
    begin
        word_kind = TK_IDENT;
        word_flag = 1'b0;
        priority if (length_reg == KW_PRINT_LEN && prefix_reg == KW_PRINT)
            word_kind = TK_PRINT;
        else if (length_reg == KW_FUNCTION_LEN && prefix_reg == KW_FUNCTION)
            word_kind = TK_FUNCTION;
        else if (length_reg == KW_RETURN_LEN && prefix_reg == KW_RETURN)
            word_kind = TK_RETURN;
        else
            word_flag = length_reg > LEN_W'(limit);
    end

    // no-pending-token handling of the character
    always_comb
    begin
        d_mode     = MODE_IDLE;
        d_emit     = 1'b0;
        d_tok      = make_tok(TK_END, 8'h00, column_reg, '0, 1'b0);
        d_word     = 1'b0;
        d_load_len = 1'b0;
        priority if (is_end(ch))
        begin
            d_emit = 1'b1;
            d_mode = MODE_LINE_START;
        end
        else if (mode_reg == MODE_LINE_START && ch == CH_TAB)
        begin
            d_mode     = MODE_INDENT;
            d_load_len = 1'b1;
        end
        else if (mode_reg == MODE_LINE_START && ch == CH_HASH)
            d_mode = MODE_COMMENT;
        else if (is_blank(ch))
            d_mode = MODE_IDLE;
        else if (is_alpha(ch))
        begin
            d_mode     = MODE_WORD;
            d_word     = 1'b1;
            d_load_len = 1'b1;
        end
        else if (is_digit(ch))
        begin
            d_mode     = MODE_NUMBER;
            d_load_len = 1'b1;
        end
        else if (ch == CH_LT)
            d_mode = MODE_LT;
        else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
        begin
            d_emit = 1'b1;
            d_tok  = make_tok(TK_OPER, ch, column_reg, 10'd1, 1'b0);
        end
        else if (ch == CH_LPAREN)
        begin
            d_emit = 1'b1;
            d_tok  = make_tok(TK_LPAREN, 8'h00, column_reg, 10'd1, 1'b0);
        end
        else if (ch == CH_RPAREN)
        begin
            d_emit = 1'b1;
            d_tok  = make_tok(TK_RPAREN, 8'h00, column_reg, 10'd1, 1'b0);
        end
        else if (ch == CH_COMMA)
        begin
            d_emit = 1'b1;
            d_tok  = make_tok(TK_COMMA, 8'h00, column_reg, 10'd1, 1'b0);
        end
        else
        begin
            d_emit = 1'b1;
            d_tok  = make_tok(TK_ERROR, ch, column_reg, 10'd1, 1'b0);
            d_mode = MODE_ERROR;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        length_next = length_reg;
        prefix_next = prefix_reg;
        pend_v      = 1'b0;
        pend_tok    = make_tok(TK_ERROR, CH_LT, start_reg, 10'd1, 1'b0);
        do_disp     = 1'b0;

        unique case (mode_reg)
            MODE_ERROR:
                mode_next = MODE_ERROR;
            MODE_COMMENT:
                if (is_end(ch))
                    mode_next = MODE_LINE_START;
            MODE_WORD:
                if (is_alpha(ch) || is_digit(ch))
                begin
                    if (length_reg < 10'd8)
                        prefix_next = prefix_reg | ({56'b0, ch} << {length_reg[2:0], 3'b000});
                    length_next = length_grown;
                end
                else
                begin
                    pend_v   = 1'b1;
                    pend_tok = make_tok(word_kind, 8'h00, start_reg, length_reg, word_flag);
                    do_disp  = 1'b1;
                end
            MODE_NUMBER:
                if (is_digit(ch) || ch == CH_DOT)
                    length_next = length_grown;
                else
                begin
                    pend_v   = 1'b1;
                    pend_tok = make_tok(TK_NUMBER, 8'h00, start_reg, length_reg, 1'b0);
                    do_disp  = 1'b1;
                end
            MODE_INDENT:
                if (ch == CH_TAB)
                    length_next = length_grown;
                else
                begin
                    pend_v   = 1'b1;
                    pend_tok = make_tok(TK_INDENT, 8'h00, '0, length_reg, 1'b0);
                    do_disp  = 1'b1;
                end
            MODE_LT:
            begin
                pend_v = 1'b1;
                if (ch == CH_MINUS)
                begin
                    pend_tok  = make_tok(TK_ASSIGN, 8'h00, start_reg, 10'd2, 1'b0);
                    mode_next = MODE_IDLE;
                end
                else
                    mode_next = MODE_ERROR;
            end
            MODE_LINE_START, MODE_IDLE:
                do_disp = 1'b1;
            default:
                mode_next = mode_reg;
        endcase

        if (do_disp)
        begin
            mode_next = d_mode;
            if (d_word || d_mode == MODE_NUMBER || d_mode == MODE_LT)
                start_next = column_reg;
            if (d_load_len)
                length_next = 10'd1;
            if (d_word)
                prefix_next = {56'b0, ch};
        end

        if (is_end(ch))
            column_next = '0;
        else if (column_reg < COL_MAX)
            column_next = column_reg + 1'b1;
        else
            column_next = column_reg;
    end

    always_comb
    begin
        push.v0      = fire && (pend_v || (do_disp && d_emit));
        push.v1      = fire && pend_v && do_disp && d_emit;
        push.t0      = pend_v ? pend_tok : d_tok;
        push.t0.last = !(pend_v && do_disp && d_emit);
        push.t1      = d_tok;
        push.t1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LINE_START;
            column_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            prefix_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            column_reg <= column_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            prefix_reg <= prefix_next;
        end
    end

    `LLT_ASSERT_NEXT(a_error_holds, mode_reg == MODE_ERROR, mode_reg == MODE_ERROR, "error state left before reset")
    `LLT_ASSERT(a_word_len, !((mode_reg == MODE_WORD || mode_reg == MODE_NUMBER || mode_reg == MODE_INDENT) && length_reg == '0), "pending token with zero length")

endmodule

`default_nettype wire

### sv/llt_queue.sv
// ----------------------------------------------------------------------------
// llt_queue
// small token queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_lexer_tokenizer_core_macros.svh"

module llt_queue
    import llt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  push_t      push,
    output logic       space,
    output logic       head_valid,
    output token_t     head,
    input  wire logic  pop
);

    token_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    assign space        = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = slot_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.v0) + QPTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            slot_reg[wr_ptr_reg] <= push.t0;
        if (push.v1)
            slot_reg[wr_ptr_plus1] <= push.t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LLT_ASSERT(a_no_overflow, !(push.v0 && count_reg > QCNT_W'(QUEUE_DEPTH - 2)), "push into full queue")
    `LLT_ASSERT(a_pair_order, !(push.v1 && !push.v0), "second token without first")
    `LLT_ASSERT(a_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

### sv/line_lexer_tokenizer_core.sv
// ----------------------------------------------------------------------------
// line_lexer_tokenizer_core
// line lexer, one source byte in, zero to two tokens out
// ----------------------------------------------------------------------------
// usage
//   src carries one character byte per word; tok carries one token per word,
//   with last set on the final token that a character causes
//   a character is taken into an input register and scanned from there once
//   the queue has room; its tokens are registered into a four-entry queue
//   whose head drives tok
//   one character per cycle is accepted while the queue has room for two
//   tokens; a character that completes a pending token can give two tokens,
//   so sustained input rate is bounded by one token per cycle at tok
//   a stalled tok receiver fills the queue, then src.ready drops; nothing
//   is lost or repeated
//   reset returns the scanner to line start at column zero, empties the
//   queue and sets the identifier length limit to twelve
//   after an error token the block swallows every character until reset
//   the limit register sits at byte address 0 of the apb port; write it only
//   while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module line_lexer_tokenizer_core
    import llt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    llt_char_if.sink               src,
    llt_token_if.source            tok,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic               in_valid_reg;
    logic [7:0]         ch_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               fire;
    logic               space;
    logic               head_valid;
    token_t             head;
    push_t              push;
    logic               sel_limit;

    assign fire      = in_valid_reg && space;
    assign src.ready = !in_valid_reg || fire;
    assign pready    = 1'b1;
    assign sel_limit = paddr[ADDR_W-1] == REG_IDENT_LIMIT[ADDR_W-1];
    assign prdata    = sel_limit ? DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            if (src.ready)
                in_valid_reg <= src.valid;
            if (psel && penable && pwrite && sel_limit)
                limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.ready && src.valid)
            ch_reg <= src.ch;
    end

    llt_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .limit (limit_reg),
        .push  (push)
    );

    llt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (tok.ready)
    );

    assign tok.valid        = head_valid;
    assign tok.token_kind   = head.kind;
    assign tok.symbol       = head.symbol;
    assign tok.start_column = head.start_column;
    assign tok.token_length = head.token_length;
    assign tok.too_long     = head.too_long;
    assign tok.last         = head.last;

endmodule

`default_nettype wire

### tb/tb_line_lexer_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_line_lexer_tokenizer_core
// random source lines streamed one byte per word, tokens checked against a
// scanner model in the bench; identifier limit swept between phases, one
// line past the column and length ceilings, run closes in the error hold
// ----------------------------------------------------------------------------
module tb_line_lexer_tokenizer_core
    import llt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COLUMN_TOP = (LINE_LENGTH - 1 < 1023) ? LINE_LENGTH - 1 : 1023;
    localparam logic [9:0]  LENGTH_TOP = 10'd1023;

    typedef enum {CC_LETTER, CC_DIGIT, CC_END, CC_BLANK, CC_OTHER} char_class_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    llt_char_if  src_ch ();
    llt_token_if tok_ch ();

    line_lexer_tokenizer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .src     (src_ch),
        .tok     (tok_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  source_bytes[$];
    token_t      expected_tokens[$];
    token_t      step_tokens[$];

    scan_mode_t  lx_mode  = MODE_LINE_START;
    logic [9:0]  lx_col   = '0;
    logic [9:0]  lx_start = '0;
    logic [9:0]  lx_len   = '0;
    logic [5:0]  lx_limit = 6'd12;
    string       lx_word  = "";

    logic        byte_offered = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    int unsigned send_pct     = 0;
    int unsigned take_pct     = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned tokens_seen  = 0;
    int unsigned fault_count  = 0;
    int unsigned kind_hits[13];
    string       limit_log    = "12";
    token_t      seen;
    token_t      want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // scanner model
    function automatic char_class_t classify(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return CC_LETTER;
        if (c >= "0" && c <= "9")
            return CC_DIGIT;
        if (c == CH_LF || c == CH_NUL)
            return CC_END;
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)
            return CC_BLANK;
        return CC_OTHER;
    endfunction

    function automatic void add_token(input tok_kind_t kind, input logic [7:0] sym,
                                      input logic [9:0] col, input logic [9:0] len,
                                      input logic flag);
        token_t t;
        t.kind         = kind;
        t.symbol       = sym;
        t.start_column = col;
        t.token_length = len;
        t.too_long     = flag;
        t.last         = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void grow_len();
        if (lx_len < LENGTH_TOP)
            lx_len++;
    endfunction

    function automatic void close_word();
        tok_kind_t kind;
        logic      flag;
        kind = TK_IDENT;
        flag = 1'b0;
        if (lx_len == 5 && lx_word == "print")
            kind = TK_PRINT;
        else if (lx_len == 8 && lx_word == "function")
            kind = TK_FUNCTION;
        else if (lx_len == 6 && lx_word == "return")
            kind = TK_RETURN;
        else if (lx_len > lx_limit)
            flag = 1'b1;
        add_token(kind, 8'h00, lx_start, lx_len, flag);
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic at_line_start);
        char_class_t cls;
        cls = classify(c);
        lx_mode = MODE_IDLE;
        if (cls == CC_END)
        begin
            add_token(TK_END, 8'h00, lx_col, 10'd0, 1'b0);
            lx_mode = MODE_LINE_START;
        end
        else if (at_line_start && c == CH_TAB)
        begin
            lx_mode = MODE_INDENT;
            lx_len  = 10'd1;
        end
        else if (at_line_start && c == CH_HASH)
        begin
            lx_mode = MODE_COMMENT;
        end
        else if (cls == CC_BLANK)
        begin
        end
        else if (cls == CC_LETTER)
        begin
            lx_mode  = MODE_WORD;
            lx_start = lx_col;
            lx_len   = 10'd1;
            lx_word  = $sformatf("%c", c);
        end
        else if (cls == CC_DIGIT)
        begin
            lx_mode  = MODE_NUMBER;
            lx_start = lx_col;
            lx_len   = 10'd1;
        end
        else if (c == CH_LT)
        begin
            lx_mode  = MODE_LT;
            lx_start = lx_col;
        end
        else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH)
            add_token(TK_OPER, c, lx_col, 10'd1, 1'b0);
        else if (c == CH_LPAREN)
            add_token(TK_LPAREN, 8'h00, lx_col, 10'd1, 1'b0);
        else if (c == CH_RPAREN)
            add_token(TK_RPAREN, 8'h00, lx_col, 10'd1, 1'b0);
        else if (c == CH_COMMA)
            add_token(TK_COMMA, 8'h00, lx_col, 10'd1, 1'b0);
        else
        begin
            add_token(TK_ERROR, c, lx_col, 10'd1, 1'b0);
            lx_mode = MODE_ERROR;
        end
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        char_class_t cls;
        token_t      t;
        cls = classify(c);
        step_tokens.delete();
        case (lx_mode)
            MODE_ERROR: ;
            MODE_COMMENT:
                if (cls == CC_END)
                    lx_mode = MODE_LINE_START;
            MODE_WORD:
                if (cls == CC_LETTER || cls == CC_DIGIT)
                begin
                    if (lx_len < 8)
                        lx_word = $sformatf("%s%c", lx_word, c);
                    grow_len();
                end
                else
                begin
                    close_word();
                    open_token(c, 1'b0);
                end
            MODE_NUMBER:
                if (cls == CC_DIGIT || c == CH_DOT)
                    grow_len();
                else
                begin
                    add_token(TK_NUMBER, 8'h00, lx_start, lx_len, 1'b0);
                    open_token(c, 1'b0);
                end
            MODE_INDENT:
                if (c == CH_TAB)
                    grow_len();
                else
                begin
                    add_token(TK_INDENT, 8'h00, 10'd0, lx_len, 1'b0);
                    open_token(c, 1'b0);
                end
            MODE_LT:
                if (c == CH_MINUS)
                begin
                    add_token(TK_ASSIGN, 8'h00, lx_start, 10'd2, 1'b0);
                    lx_mode = MODE_IDLE;
                end
                else
                begin
                    add_token(TK_ERROR, CH_LT, lx_start, 10'd1, 1'b0);
                    lx_mode = MODE_ERROR;
                end
            MODE_LINE_START:
                open_token(c, 1'b1);
            default:
                open_token(c, 1'b0);
        endcase
        if (cls == CC_END)
            lx_col = '0;
        else if (lx_col < COLUMN_TOP)
            lx_col++;
        for (int i = 0; i < step_tokens.size(); i++)
        begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    // line builder
    function automatic void push_byte(input logic [7:0] b);
        source_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(97, 122));
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] any_alnum();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(48, 57));
        return any_letter();
    endfunction

    function automatic void push_line();
        string       word_pool[8];
        logic [7:0]  blank_set[5];
        logic [7:0]  op_set[4];
        logic [7:0]  b;
        int unsigned pick;
        int unsigned n;
        word_pool = '{"print", "function", "return", "printx",
                      "functions", "retur", "Return", "prin"};
        blank_set = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        op_set    = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            push_byte(CH_HASH);
            repeat ($urandom_range(0, 12))
            begin
                b = 8'($urandom_range(1, 255));
                push_byte(b == CH_LF ? CH_HASH : b);
            end
        end
        else
        begin
            if (pick < 25)
                repeat ($urandom_range(1, 3))
                    push_byte(CH_TAB);
            repeat ($urandom_range(0, 7))
            begin
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 2))
                        push_byte(blank_set[$urandom_range(0, 4)]);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                                     : $urandom_range(1, 14);
                    push_byte(any_letter());
                    repeat (n - 1)
                        push_byte(any_alnum());
                end
                else if (pick < 42)
                    push_text(word_pool[$urandom_range(0, 7)]);
                else if (pick < 55)
                begin
                    push_byte(8'($urandom_range(48, 57)));
                    repeat ($urandom_range(0, 7))
                        push_byte($urandom_range(0, 3) == 0 ? CH_DOT
                                                            : 8'($urandom_range(48, 57)));
                end
                else if (pick < 62)
                    push_text("<-");
                else if (pick < 78)
                    push_byte(op_set[$urandom_range(0, 3)]);
                else if (pick < 90)
                    push_byte($urandom_range(0, 1) == 0 ? CH_LPAREN : CH_RPAREN);
                else
                    push_byte(CH_COMMA);
            end
        end
        push_byte($urandom_range(0, 4) == 0 ? CH_NUL : CH_LF);
    endfunction

    function automatic void queue_lines(input int unsigned count);
        int unsigned goal;
        goal = bytes_queued + count;
        while (bytes_queued < goal)
            push_line();
    endfunction

    function automatic string describe(input token_t t);
        return $sformatf("kind %0d sym %02h col %0d len %0d long %0b last %0b",
                         t.kind, t.symbol, t.start_column, t.token_length,
                         t.too_long, t.last);
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic wait_quiet();
        while (source_bytes.size() > 0 || expected_tokens.size() > 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_ident_limit(input logic [5:0] value);
        logic [DATA_W-1:0] wide;
        logic [DATA_W-1:0] readback;
        wide = {{(DATA_W - 6){1'b0}}, value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_IDENT_LIMIT;
        pwdata  <= wide;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        lx_limit = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== wide)
            report_fault($sformatf("limit readback %0h, wrote %0h", readback, wide));
        limit_log = $sformatf("%s %0d", limit_log, value);
    endtask

    // character sender
    always @(negedge clk)
    begin
        if (!rst_n)
            src_ch.valid <= 1'b0;
        else if (!byte_offered)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                src_ch.valid <= 1'b0;
            end
            else if (source_bytes.size() > 0 && send_pct > 0
                     && $urandom_range(0, 99) < send_pct)
            begin
                send_gap = $urandom_range(0, 6);
                src_ch.valid <= 1'b0;
            end
            else if (source_bytes.size() > 0)
            begin
                src_ch.valid <= 1'b1;
                src_ch.ch    <= source_bytes[0];
                byte_offered = 1'b1;
            end
            else
                src_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && src_ch.valid && src_ch.ready)
        begin
            void'(source_bytes.pop_front());
            byte_offered = 1'b0;
            bytes_taken++;
            lex_char(src_ch.ch);
        end
    end

    // token receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            tok_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            tok_ch.ready <= 1'b0;
        end
        else if (take_pct > 0 && $urandom_range(0, 99) < take_pct)
        begin
            stall_left = $urandom_range(0, 6);
            tok_ch.ready <= 1'b0;
        end
        else
            tok_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            seen.kind         = tok_kind_t'(tok_ch.token_kind);
            seen.symbol       = tok_ch.symbol;
            seen.start_column = tok_ch.start_column;
            seen.token_length = tok_ch.token_length;
            seen.too_long     = tok_ch.too_long;
            seen.last         = tok_ch.last;
            tokens_seen++;
            if (tok_ch.token_kind <= TK_ERROR)
                kind_hits[tok_ch.token_kind]++;
            if (expected_tokens.size() == 0)
                report_fault({"unexpected token: ", describe(seen)});
            else
            begin
                want = expected_tokens.pop_front();
                if (seen !== want)
                    report_fault({"token mismatch, expected ", describe(want),
                                  " got ", describe(seen)});
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d bytes and %0d tokens still outstanding",
                 source_bytes.size(), expected_tokens.size());
        $display("tb_line_lexer_tokenizer_core failed");
        $finish;
    end

    initial
    begin
        logic [7:0]  bad_set[8];
        int unsigned kinds_covered;
        int unsigned waited;
        bad_set = '{"!", "#", ".", ";", "@", "~", 8'h80, 8'hFF};
        src_ch.valid = 1'b0;
        src_ch.ch    = 8'h00;
        tok_ch.ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed line: indent, keyword, assign, all operators, brackets, comment
        send_pct = 20;
        take_pct = 20;
        push_byte(CH_TAB);
        push_text("return a<-1.5*(b),c+d/e-2");
        push_byte(CH_NUL);
        push_byte(CH_HASH);
        push_byte(8'hFF);
        push_byte(CH_LF);
        wait_quiet();

        set_ident_limit(6'd0);
        send_pct = 30;
        take_pct = 30;
        @(posedge clk);
        queue_lines(110);
        wait_quiet();

        set_ident_limit(6'd63);
        send_pct = 0;
        take_pct = 0;
        @(posedge clk);
        queue_lines(110);
        wait_quiet();

        set_ident_limit(6'd1);
        send_pct = 15;
        take_pct = 45;
        @(posedge clk);
        queue_lines(110);
        wait_quiet();

        // one identifier running past the column and length ceilings
        set_ident_limit(6'd5);
        send_pct = 10;
        take_pct = 10;
        @(posedge clk);
        push_byte(any_letter());
        repeat (1029)
            push_byte(any_alnum());
        push_text("+x");
        push_byte(CH_LF);
        wait_quiet();

        set_ident_limit(6'($urandom_range(2, 62)));
        send_pct = 25;
        take_pct = 10;
        @(posedge clk);
        queue_lines(70);
        wait_quiet();

        // closing stretch without idling, ends in the error hold
        send_pct = 0;
        take_pct = 0;
        @(posedge clk);
        queue_lines(90);
        push_text("z ");
        if ($urandom_range(0, 1) == 0)
            push_text("<q");
        else
            push_byte(bad_set[$urandom_range(0, 7)]);
        repeat (40)
            push_byte(8'($urandom_range(0, 255)));

        while (source_bytes.size() > 0)
            @(negedge clk);
        waited = 0;
        while (expected_tokens.size() > 0 && waited < 200)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (expected_tokens.size() > 0)
            report_fault($sformatf("%0d expected tokens never arrived",
                                   expected_tokens.size()));

        kinds_covered = 0;
        for (int k = 0; k < 13; k++)
            if (kind_hits[k] > 0)
                kinds_covered++;
        $display("lexed %0d bytes into %0d tokens, %0d of 13 token kinds seen, %0d faults",
                 bytes_taken, tokens_seen, kinds_covered, fault_count);
        $display("identifier limits used: %s; run closed in the error hold", limit_log);
        if (fault_count == 0)
            $display("tb_line_lexer_tokenizer_core passed");
        else
            $display("tb_line_lexer_tokenizer_core failed");
        $finish;
    end

endmodule
